// ----- hdl/slt_pkg.sv -----
`timescale 1ns / 1ps

package slt_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_MISSING  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_LISTED   = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd6;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
    logic signed [VALUE_W-1:0]  head;
  } cell_ctrl_t;

endpackage

// ----- hdl/slt_cell.sv -----
`timescale 1ns / 1ps

module slt_cell (
  input  logic                                 clk,
  input  slt_pkg::cell_ctrl_t                  ctrl,
  input  logic                                 occ,
  input  logic                                 left_p,
  input  logic signed [slt_pkg::VALUE_W-1:0]   left_value,
  input  logic                                 right_occ,
  input  logic signed [slt_pkg::VALUE_W-1:0]   right_value,
  output logic signed [slt_pkg::VALUE_W-1:0]   value,
  output logic                                 p,
  output logic                                 eq
);

  logic signed [slt_pkg::VALUE_W-1:0] value_next;
  logic                               ge;

  // p marks cells at or after the insertion point; it is monotonic along the chain.
  always_comb begin
    p  = !occ || (value > ctrl.value);
    ge = occ && (value >= ctrl.value);
    eq = occ && (value == ctrl.value);
  end

  always_comb begin
    value_next = value;
    case (ctrl.op)
      slt_pkg::OP_INSERT: begin
        if (left_p) begin
          value_next = left_value;
        end else if (p) begin
          value_next = ctrl.value;
        end
      end
      slt_pkg::OP_DELETE: begin
        if (ge) begin
          value_next = right_value;
        end
      end
      slt_pkg::OP_ROTATE: begin
        // The last held cell wraps the head around so the table is restored after a full pass.
        if (right_occ) begin
          value_next = right_value;
        end else if (occ) begin
          value_next = ctrl.head;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- hdl/sorted_list_table.sv -----
`timescale 1ns / 1ps

// Sorted table of signed 32-bit values held in a chain of CAPACITY cells, ascending from
// cell 0. Insert, find and delete take one word per cycle while the output register is free
// and no list runs: every cell compares against the request value in parallel and shifts
// toward or away from its neighbor in one step. A list request emits the entries in turn as
// the chain rotates them through the head cell, which feeds the output register. The output
// register lets a new request be taken in the same cycle a finished word leaves. Entries
// above the held count are never read, so the cells need no clearing after reset.
module sorted_list_table #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [slt_pkg::REQ_W-1:0]             req_type,
  input  logic signed [slt_pkg::VALUE_W-1:0]    item_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [slt_pkg::STATUS_W-1:0]          status,
  output logic signed [slt_pkg::VALUE_W-1:0]    entry_value,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count,
  output logic                                  last
);

  localparam int CW = $clog2(CAPACITY + 1);

  slt_pkg::state_t     state, state_next;
  slt_pkg::cell_ctrl_t ctrl;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] list_left;

  logic signed [slt_pkg::VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] occ, p, eq;

  logic accept, out_free, emit_list, full, found, list_start;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign full       = (count == CW'(CAPACITY));
  assign found      = |eq;
  assign list_start = accept && (req_type == slt_pkg::REQ_LIST) && (count != '0);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CW'(i) < count);
    end
  end

  always_comb begin
    ctrl.value = item_value;
    ctrl.head  = cell_value[0];
    ctrl.op    = slt_pkg::OP_HOLD;
    count_next = count;
    if (accept && (req_type == slt_pkg::REQ_INSERT) && !full) begin
      ctrl.op    = slt_pkg::OP_INSERT;
      count_next = count + CW'(1);
    end else if (accept && (req_type == slt_pkg::REQ_DELETE) && found) begin
      ctrl.op    = slt_pkg::OP_DELETE;
      count_next = count - CW'(1);
    end else if (emit_list) begin
      ctrl.op = slt_pkg::OP_ROTATE;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                               lp, ro;
    logic signed [slt_pkg::VALUE_W-1:0] lv, rv;
    if (g == 0) begin : g_first
      assign lp = 1'b0;
      assign lv = '0;
    end else begin : g_mid_l
      assign lp = p[g-1];
      assign lv = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign ro = 1'b0;
      assign rv = '0;
    end else begin : g_mid_r
      assign ro = occ[g+1];
      assign rv = cell_value[g+1];
    end
    slt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[g]),
      .left_p      (lp),
      .left_value  (lv),
      .right_occ   (ro),
      .right_value (rv),
      .value       (cell_value[g]),
      .p           (p[g]),
      .eq          (eq[g])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      slt_pkg::ST_IDLE: begin
        if (list_start) begin
          state_next = slt_pkg::ST_LIST;
        end
      end
      slt_pkg::ST_LIST: begin
        if (emit_list && (list_left == CW'(1))) begin
          state_next = slt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    emit_list = 1'b0;
    case (state)
      slt_pkg::ST_IDLE: begin
        in_ready = out_free;
      end
      slt_pkg::ST_LIST: begin
        emit_list = out_free;
      end
      default: begin
        in_ready  = 1'b0;
        emit_list = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slt_pkg::ST_IDLE;
      count     <= '0;
      list_left <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (list_start) begin
        list_left <= count;
      end else if (emit_list) begin
        list_left <= list_left - CW'(1);
      end
      if ((accept && !list_start) || emit_list) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_list) begin
      status      <= slt_pkg::STAT_LISTED;
      entry_value <= cell_value[0];
      entry_count <= count;
      last        <= (list_left == CW'(1));
    end else if (accept && !list_start) begin
      entry_value <= item_value;
      entry_count <= count_next;
      last        <= 1'b1;
      case (req_type)
        slt_pkg::REQ_INSERT: status <= full ? slt_pkg::STAT_FULL : slt_pkg::STAT_INSERTED;
        slt_pkg::REQ_FIND:   status <= found ? slt_pkg::STAT_FOUND : slt_pkg::STAT_MISSING;
        slt_pkg::REQ_DELETE: status <= found ? slt_pkg::STAT_DELETED : slt_pkg::STAT_MISSING;
        default: begin
          status      <= slt_pkg::STAT_EMPTY;
          entry_value <= '0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("held count exceeds capacity");

  a_no_accept_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == slt_pkg::ST_LIST) |-> !in_ready)
    else $error("request taken while listing");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type == slt_pkg::REQ_INSERT) && !full) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the table");

  a_list_restores: assert property (@(posedge clk) disable iff (rst)
    (emit_list && (list_left == CW'(1))) |=> (state == slt_pkg::ST_IDLE && count == $past(count)))
    else $error("list pass did not end cleanly");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  typedef struct {
    logic [slt_pkg::STATUS_W-1:0]       status;
    logic signed [slt_pkg::VALUE_W-1:0] value;
    logic [COUNT_W-1:0]                 count;
    logic                               last;
  } result_word_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [slt_pkg::REQ_W-1:0]          req_type = slt_pkg::REQ_INSERT;
  logic signed [slt_pkg::VALUE_W-1:0] item_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [slt_pkg::STATUS_W-1:0]       status;
  logic signed [slt_pkg::VALUE_W-1:0] entry_value;
  logic [COUNT_W-1:0]                 entry_count;
  logic                               last;

  // Shadow copy of the table, updated as each request word is accepted.
  logic signed [slt_pkg::VALUE_W-1:0] table_vals [CAPACITY];
  int                                 table_count = 0;
  result_word_t                       expected_words [$];
  int                                 err_count = 0;
  bit                                 idle_en = 1'b1;
  int                                 stall_left = 0;

  logic signed [slt_pkg::VALUE_W-1:0] value_pool [8] = '{
    32'sh80000000, 32'sh7fffffff, 32'sh00000000, -32'sd1,
    32'sd1, 32'sd100, -32'sd100, 32'sh5a5a5a5a
  };

  sorted_list_table #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .item_value(item_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .entry_value(entry_value),
    .entry_count(entry_count),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL sorted_list_table");
    $finish;
  end

  task automatic push_word(input logic [slt_pkg::STATUS_W-1:0] st,
                           input logic signed [slt_pkg::VALUE_W-1:0] v,
                           input bit is_last);
    result_word_t w;
    w.status = st;
    w.value  = v;
    w.count  = table_count[COUNT_W-1:0];
    w.last   = is_last;
    expected_words.push_back(w);
  endtask

  // Applies one accepted request to the shadow table and queues its result words.
  task automatic apply_request(input logic [slt_pkg::REQ_W-1:0] req,
                               input logic signed [slt_pkg::VALUE_W-1:0] v);
    int pos;
    int i;
    pos = 0;
    case (req)
      slt_pkg::REQ_INSERT: begin
        if (table_count >= CAPACITY) begin
          push_word(slt_pkg::STAT_FULL, v, 1'b1);
        end else begin
          // Equal values go after the ones already held.
          while (pos < table_count && table_vals[pos] <= v) pos++;
          for (i = table_count; i > pos; i--) table_vals[i] = table_vals[i-1];
          table_vals[pos] = v;
          table_count++;
          push_word(slt_pkg::STAT_INSERTED, v, 1'b1);
        end
      end
      slt_pkg::REQ_FIND, slt_pkg::REQ_DELETE: begin
        while (pos < table_count && table_vals[pos] != v) pos++;
        if (pos >= table_count) begin
          push_word(slt_pkg::STAT_MISSING, v, 1'b1);
        end else if (req == slt_pkg::REQ_FIND) begin
          push_word(slt_pkg::STAT_FOUND, v, 1'b1);
        end else begin
          for (i = pos; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
          table_count--;
          push_word(slt_pkg::STAT_DELETED, v, 1'b1);
        end
      end
      default: begin
        if (table_count == 0) begin
          push_word(slt_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < table_count; i++)
            push_word(slt_pkg::STAT_LISTED, table_vals[i], i + 1 == table_count);
        end
      end
    endcase
  endtask

  // Sends one request word; valid stays high afterwards unless a gap is taken next time.
  task automatic send_request(input logic [slt_pkg::REQ_W-1:0] req,
                              input logic signed [slt_pkg::VALUE_W-1:0] v);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    item_value <= v;
    do @(posedge clk); while (!in_ready);
    apply_request(req, v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: status %0d value %0d count %0d last %0d",
                   status, entry_value, entry_count, last);
      end else begin
        w = expected_words.pop_front();
        if (status !== w.status || entry_value !== w.value ||
            entry_count !== w.count || last !== w.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected st %0d val %0d cnt %0d last %0d, got %0d %0d %0d %0d",
                     w.status, w.value, w.count, w.last,
                     status, entry_value, entry_count, last);
        end
      end
    end
  end

  task automatic test_empty_table();
    send_request(slt_pkg::REQ_LIST, 32'sh12345678);
    send_request(slt_pkg::REQ_DELETE, 32'sd0);
    send_request(slt_pkg::REQ_FIND, -32'sd1);
  endtask

  task automatic test_extremes();
    send_request(slt_pkg::REQ_INSERT, 32'sh80000000);
    send_request(slt_pkg::REQ_INSERT, 32'sh7fffffff);
    send_request(slt_pkg::REQ_INSERT, 32'sd0);
    send_request(slt_pkg::REQ_INSERT, -32'sd1);
    // A value equal to the head must still be inserted.
    send_request(slt_pkg::REQ_INSERT, 32'sh80000000);
    send_request(slt_pkg::REQ_FIND, 32'sh7fffffff);
    send_request(slt_pkg::REQ_FIND, 32'sd5);
    send_request(slt_pkg::REQ_DELETE, 32'sh80000000);
    send_request(slt_pkg::REQ_DELETE, 32'sd12345);
  endtask

  task automatic test_full_table();
    while (table_count < CAPACITY)
      send_request(slt_pkg::REQ_INSERT, value_pool[$urandom_range(0, 7)]);
    send_request(slt_pkg::REQ_INSERT, 32'sh7fffffff);
    send_request(slt_pkg::REQ_LIST, '0);
  endtask

  // Grow and shrink phases alternate so the table swings between empty and full.
  task automatic test_random_mix(input int n_items, input bit allow_idle);
    int roll;
    int pick;
    bit grow;
    logic [slt_pkg::REQ_W-1:0] req;
    logic signed [slt_pkg::VALUE_W-1:0] v;
    idle_en = allow_idle;
    grow = 1'b0;
    for (int n = 0; n < n_items; n++) begin
      if (n % 20 == 0) grow = !grow;
      roll = $urandom_range(0, 99);
      if (roll < (grow ? 55 : 15))      req = slt_pkg::REQ_INSERT;
      else if (roll < (grow ? 70 : 30)) req = slt_pkg::REQ_FIND;
      else if (roll < 85)               req = slt_pkg::REQ_DELETE;
      else                              req = slt_pkg::REQ_LIST;
      pick = $urandom_range(0, 9);
      if (pick < 4 && table_count > 0)
        v = table_vals[$urandom_range(0, table_count - 1)];
      else if (pick < 7)
        v = value_pool[$urandom_range(0, 7)];
      else
        v = $urandom;
      send_request(req, v);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_extremes();
    test_full_table();
    test_random_mix(140, 1'b1);
    test_random_mix(30, 1'b0);
    idle_en = 1'b0;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0)
      $display("PASS sorted_list_table");
    else
      $display("FAIL sorted_list_table");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/slt_pkg.sv
hdl/slt_cell.sv
hdl/sorted_list_table.sv
tb/tb_top.sv
